### rtl/core/cnms_pkg.sv
package cnms_pkg;

  localparam int NCand = 256;
  localparam int AddrW = $clog2(NCand);
  localparam int CntW  = AddrW + 1;
  localparam int MaxOut = 32;
  localparam int KeepW = 6;
  localparam int CoordW = 16;
  localparam int BoxW = 4 * CoordW;
  localparam int ScoreW = 16;
  localparam int ClassW = 3;
  localparam int ScW = ScoreW + ClassW;
  localparam int AreaW = 2 * CoordW;

  localparam logic [15:0] ThrReset  = 16'd29491;
  localparam logic [5:0]  KeepReset = 6'd20;

  // Configuration register indexes.
  localparam logic CfgThr  = 1'b0;
  localparam logic CfgKeep = 1'b1;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SCAN,
    S_DEC,
    S_EMIT_MID,
    S_PICK,
    S_LATCH,
    S_SUPP,
    S_EMIT_END
  } state_t;

  // Write and read requests into the candidate store. The mark port clears an
  // entry's suppressed bit when the candidate loads and sets it when the entry
  // is kept or suppressed.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [BoxW-1:0]  box;
    logic [ScW-1:0]   sc;
    logic             mwe;
    logic [AddrW-1:0] maddr;
    logic             mbit;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  function automatic logic [CoordW-1:0] span(input logic [CoordW-1:0] lo,
                                             input logic [CoordW-1:0] hi);
    span = (hi > lo) ? hi - lo : '0;
  endfunction

endpackage

### rtl/core/cnms_if.sv
interface cnms_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_x;
  logic [15:0] top_y;
  logic [15:0] right_x;
  logic [15:0] bottom_y;
  logic [2:0]  object_class;
  logic [15:0] confidence;
  logic        final_item;

  modport source (output valid, left_x, top_y, right_x, bottom_y, object_class,
                  confidence, final_item, input ready);
  modport sink (input valid, left_x, top_y, right_x, bottom_y, object_class,
                confidence, final_item, output ready);
endinterface

interface cnms_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] out_left_x;
  logic [15:0] out_top_y;
  logic [15:0] out_right_x;
  logic [15:0] out_bottom_y;
  logic [2:0]  out_class;
  logic [15:0] out_confidence;
  logic [7:0]  arrival_index;
  logic        dropped_some;
  logic        run_end;

  modport source (output valid, found, out_left_x, out_top_y, out_right_x,
                  out_bottom_y, out_class, out_confidence, arrival_index,
                  dropped_some, run_end, input ready);
  modport sink (input valid, found, out_left_x, out_top_y, out_right_x,
                out_bottom_y, out_class, out_confidence, arrival_index,
                dropped_some, run_end, output ready);
endinterface

### rtl/core/cnms_store.sv
module cnms_store (
  input  logic                      clk,
  input  cnms_pkg::mem_req_t        req,
  output logic [cnms_pkg::BoxW-1:0] box_q,
  output logic [cnms_pkg::ScW-1:0]  sc_q,
  output logic                      done_q
);

  logic [cnms_pkg::BoxW-1:0] box_mem [cnms_pkg::NCand];
  logic [cnms_pkg::ScW-1:0]  sc_mem  [cnms_pkg::NCand];
  logic                      done_mem [cnms_pkg::NCand];

  // One write port and one registered read port on both arrays.
  always_ff @(posedge clk) begin
    if (req.we) begin
      box_mem[req.waddr] <= req.box;
      sc_mem[req.waddr]  <= req.sc;
    end
    box_q <= box_mem[req.raddr];
    sc_q  <= sc_mem[req.raddr];
  end

  // Suppressed marks share the read address with the candidate data.
  always_ff @(posedge clk) begin
    if (req.mwe) done_mem[req.maddr] <= req.mbit;
    done_q <= done_mem[req.raddr];
  end

endmodule

### rtl/core/cnms_iou.sv
module cnms_iou (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_v,
  input  logic [cnms_pkg::AddrW-1:0]   in_idx,
  input  logic [cnms_pkg::BoxW-1:0]    box_a,
  input  logic [cnms_pkg::AreaW-1:0]   area_a,
  input  logic [cnms_pkg::BoxW-1:0]    box_b,
  input  logic [15:0]                  thr,
  output logic                         mark_v,
  output logic [cnms_pkg::AddrW-1:0]   mark_idx,
  output logic                         busy
);

  logic [15:0] al, at, ar, ab, bl, bt, br, bb;
  logic [15:0] il, it, ir, ib;
  logic [15:0] bw, bh, iw, ih;

  logic                        v1_r, v2_r;
  logic [cnms_pkg::AddrW-1:0]  idx1_r, idx2_r;
  logic [cnms_pkg::AreaW-1:0]  inter1_r, areab1_r, inter2_r;
  logic [cnms_pkg::AreaW:0]    uni2_r;
  logic [cnms_pkg::AreaW+16:0] rhs;
  logic [cnms_pkg::AreaW+16:0] lhs;

  // Corner unpacking and the intersection rectangle.
  always_comb begin
    al = box_a[15:0];  at = box_a[31:16]; ar = box_a[47:32]; ab = box_a[63:48];
    bl = box_b[15:0];  bt = box_b[31:16]; br = box_b[47:32]; bb = box_b[63:48];
    il = (al > bl) ? al : bl;
    it = (at > bt) ? at : bt;
    ir = (ar < br) ? ar : br;
    ib = (ab < bb) ? ab : bb;
    iw = cnms_pkg::span(il, ir);
    ih = cnms_pkg::span(it, ib);
    bw = cnms_pkg::span(bl, br);
    bh = cnms_pkg::span(bt, bb);
  end

  // Stage one holds the products, stage two the union.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
    idx1_r   <= in_idx;
    inter1_r <= iw * ih;
    areab1_r <= bw * bh;
    idx2_r   <= idx1_r;
    inter2_r <= inter1_r;
    uni2_r   <= {1'b0, area_a} + {1'b0, areab1_r} - {1'b0, inter1_r};
  end

  // Suppress when inter * 2^16 exceeds threshold * union.
  always_comb begin
    rhs      = {{(cnms_pkg::AreaW+1-16){1'b0}}, thr} * {16'd0, uni2_r};
    lhs      = {1'b0, inter2_r, 16'd0};
    mark_v   = v2_r && (uni2_r != '0) && (lhs > rhs);
    mark_idx = idx2_r;
    busy     = v1_r || v2_r;
  end

endmodule

### rtl/core/class_aware_nms_top.sv
// Candidates load at one beat per cycle while the block is in its load phase.
// After the final beat, each kept box costs a score scan, a pick and latch step and
// a suppression scan, and its result beat is emitted before the next pick; a run
// ends with one more score scan if fewer than max_keep survive.
// Synchronous active-low reset clears control state and the configuration
// registers to their defaults; the candidate store is not cleared.
module class_aware_nms_top (
  input  logic                clk,
  input  logic                rst_n,
  cnms_in_if.sink             in_ch,
  cnms_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [15:0]         cfg_data
);

  localparam int AW = cnms_pkg::AddrW;
  localparam int CW = cnms_pkg::CntW;

  cnms_pkg::state_t state_r, state_nxt;
  cnms_pkg::mem_req_t req;

  logic [15:0]                  thr_r;
  logic [5:0]                   mk_r;
  logic [5:0]                   lim;
  logic [CW-1:0]                cnt_r, n_r, a_r;
  logic                         ovf_r, run_ovf_r;
  logic                         rd_v_r;
  logic [AW-1:0]                rd_idx_r;
  logic                         best_v_r;
  logic [AW-1:0]                best_idx_r;
  logic [cnms_pkg::ScW-1:0]     best_sc_r;
  logic [cnms_pkg::BoxW-1:0]    pend_box_r;
  logic [cnms_pkg::ScW-1:0]     pend_sc_r;
  logic [AW-1:0]                pend_idx_r;
  logic [cnms_pkg::AreaW-1:0]   pend_area_r;
  logic                         have_pend_r;
  logic [5:0]                   kept_r;
  logic [cnms_pkg::BoxW-1:0]    box_q;
  logic [cnms_pkg::ScW-1:0]     sc_q;
  logic                         done_q;

  logic in_acc, out_free, issue, scan_end, supp_end, elig;
  logic mark_v, iou_busy;
  logic [AW-1:0] mark_idx;

  logic out_valid_r, found_r, dropped_r, run_end_r;
  logic [cnms_pkg::BoxW-1:0] out_box_r;
  logic [cnms_pkg::ScW-1:0]  out_sc_r;
  logic [AW-1:0]             out_idx_r;

  // Handshake and scan control.
  always_comb begin
    in_ch.ready = (state_r == cnms_pkg::S_LOAD);
    in_acc      = in_ch.valid && in_ch.ready;
    out_free    = !out_valid_r || out_ch.ready;
    issue       = (a_r < n_r) &&
                  (state_r == cnms_pkg::S_SCAN || state_r == cnms_pkg::S_SUPP);
    scan_end    = (a_r == n_r) && !rd_v_r;
    supp_end    = scan_end && !iou_busy;
    elig        = rd_v_r && (state_r == cnms_pkg::S_SUPP) && !done_q &&
                  (sc_q[18:16] == pend_sc_r[18:16]);
    if (mk_r == 6'd0)
      lim = 6'd1;
    else if (mk_r > 6'(cnms_pkg::MaxOut))
      lim = 6'(cnms_pkg::MaxOut);
    else
      lim = mk_r;
  end

  // Store requests.
  always_comb begin
    req.we    = in_acc && (cnt_r < CW'(cnms_pkg::NCand));
    req.waddr = cnt_r[AW-1:0];
    req.box   = {in_ch.bottom_y, in_ch.right_x, in_ch.top_y, in_ch.left_x};
    req.sc    = {in_ch.object_class, in_ch.confidence};
    req.mwe   = req.we || (state_r == cnms_pkg::S_LATCH) || mark_v;
    req.maddr = req.we ? req.waddr :
                ((state_r == cnms_pkg::S_LATCH) ? best_idx_r : mark_idx);
    req.mbit  = !req.we;
    req.raddr = (state_r == cnms_pkg::S_PICK) ? best_idx_r : a_r[AW-1:0];
  end

  cnms_store u_store (
    .clk    (clk),
    .req    (req),
    .box_q  (box_q),
    .sc_q   (sc_q),
    .done_q (done_q)
  );

  cnms_iou u_iou (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (elig),
    .in_idx   (rd_idx_r),
    .box_a    (pend_box_r),
    .area_a   (pend_area_r),
    .box_b    (box_q),
    .thr      (thr_r),
    .mark_v   (mark_v),
    .mark_idx (mark_idx),
    .busy     (iou_busy)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cnms_pkg::S_LOAD:
        if (in_acc && in_ch.final_item) state_nxt = cnms_pkg::S_SCAN;
      cnms_pkg::S_SCAN:
        if (scan_end) state_nxt = cnms_pkg::S_DEC;
      cnms_pkg::S_DEC:
        if (!best_v_r) state_nxt = cnms_pkg::S_EMIT_END;
        else if (have_pend_r) state_nxt = cnms_pkg::S_EMIT_MID;
        else state_nxt = cnms_pkg::S_PICK;
      cnms_pkg::S_EMIT_MID:
        if (out_free) state_nxt = cnms_pkg::S_PICK;
      cnms_pkg::S_PICK:
        state_nxt = cnms_pkg::S_LATCH;
      cnms_pkg::S_LATCH:
        if (kept_r + 6'd1 == lim) state_nxt = cnms_pkg::S_EMIT_END;
        else state_nxt = cnms_pkg::S_SUPP;
      cnms_pkg::S_SUPP:
        if (supp_end) state_nxt = cnms_pkg::S_SCAN;
      cnms_pkg::S_EMIT_END:
        if (out_free) state_nxt = cnms_pkg::S_LOAD;
      default:
        state_nxt = cnms_pkg::S_LOAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cnms_pkg::S_LOAD;
      thr_r       <= cnms_pkg::ThrReset;
      mk_r        <= cnms_pkg::KeepReset;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      rd_v_r      <= 1'b0;
      best_v_r    <= 1'b0;
      have_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      kept_r      <= '0;
      a_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          cnms_pkg::CfgThr:  thr_r <= cfg_data;
          cnms_pkg::CfgKeep: mk_r  <= cfg_data[5:0];
          default: ;
        endcase
      end
      rd_v_r <= issue;
      if (issue) a_r <= a_r + CW'(1);

      // In the emit states, a new result beat is offered when the output register is free.
      if ((state_r == cnms_pkg::S_EMIT_MID || state_r == cnms_pkg::S_EMIT_END) &&
          out_free)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;

      case (state_r)
        cnms_pkg::S_LOAD: begin
          if (in_acc) begin
            if (in_ch.final_item) begin
              cnt_r       <= '0;
              ovf_r       <= 1'b0;
              a_r         <= '0;
              best_v_r    <= 1'b0;
              have_pend_r <= 1'b0;
              kept_r      <= '0;
            end else if (req.we) begin
              cnt_r <= cnt_r + CW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
          end
        end
        cnms_pkg::S_SCAN: begin
          if (rd_v_r && !done_q &&
              (!best_v_r || sc_q[15:0] > best_sc_r[15:0])) begin
            best_v_r <= 1'b1;
          end
        end
        cnms_pkg::S_LATCH: begin
          have_pend_r <= 1'b1;
          kept_r      <= kept_r + 6'd1;
          a_r         <= '0;
        end
        cnms_pkg::S_SUPP: begin
          if (supp_end) begin
            a_r      <= '0;
            best_v_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    rd_idx_r <= a_r[AW-1:0];
    if (in_acc && in_ch.final_item) begin
      n_r       <= req.we ? cnt_r + CW'(1) : cnt_r;
      run_ovf_r <= ovf_r || !req.we;
    end
    if (state_r == cnms_pkg::S_SCAN && rd_v_r && !done_q &&
        (!best_v_r || sc_q[15:0] > best_sc_r[15:0])) begin
      best_idx_r <= rd_idx_r;
      best_sc_r  <= sc_q;
    end
    if (state_r == cnms_pkg::S_LATCH) begin
      pend_box_r  <= box_q;
      pend_sc_r   <= best_sc_r;
      pend_idx_r  <= best_idx_r;
      pend_area_r <= cnms_pkg::span(box_q[15:0], box_q[47:32]) *
                     cnms_pkg::span(box_q[31:16], box_q[63:48]);
    end
    if ((state_r == cnms_pkg::S_EMIT_MID || state_r == cnms_pkg::S_EMIT_END) &&
        out_free) begin
      found_r   <= have_pend_r;
      out_box_r <= have_pend_r ? pend_box_r : '0;
      out_sc_r  <= have_pend_r ? pend_sc_r : '0;
      out_idx_r <= have_pend_r ? pend_idx_r : '0;
      dropped_r <= run_ovf_r;
      run_end_r <= (state_r == cnms_pkg::S_EMIT_END);
    end
  end

  // Output beat.
  assign out_ch.valid          = out_valid_r;
  assign out_ch.found          = found_r;
  assign out_ch.out_left_x     = out_box_r[15:0];
  assign out_ch.out_top_y      = out_box_r[31:16];
  assign out_ch.out_right_x    = out_box_r[47:32];
  assign out_ch.out_bottom_y   = out_box_r[63:48];
  assign out_ch.out_class      = out_sc_r[18:16];
  assign out_ch.out_confidence = out_sc_r[15:0];
  assign out_ch.arrival_index  = out_idx_r;
  assign out_ch.dropped_some   = dropped_r;
  assign out_ch.run_end        = run_end_r;

endmodule

### rtl/core/cnms_chk.sv
module cnms_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic        run_end,
  input logic [15:0] out_confidence
);

  // A stalled result beat stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its confidence and run-end flag.
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_confidence) && $stable(run_end))
    else $error("result payload changed while stalled");

  // Reset leaves no result offered.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // An empty result always closes its run.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> run_end)
    else $error("empty result not marked as run end");

endmodule

bind class_aware_nms_top cnms_chk u_cnms_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .found          (out_ch.found),
  .run_end        (out_ch.run_end),
  .out_confidence (out_ch.out_confidence)
);

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int WatchLimit = 40000;

  typedef struct packed {
    logic [15:0] lx;
    logic [15:0] ty;
    logic [15:0] rx;
    logic [15:0] by;
    logic [2:0]  cls;
    logic [15:0] conf;
    logic        fin;
  } cand_t;

  typedef struct packed {
    logic        found;
    logic [15:0] lx;
    logic [15:0] ty;
    logic [15:0] rx;
    logic [15:0] by;
    logic [2:0]  cls;
    logic [15:0] conf;
    logic [7:0]  idx;
    logic        dropped;
    logic        last;
  } kept_box_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_idx = cnms_pkg::CfgThr;
  logic [15:0] cfg_data = '0;

  cnms_in_if  in_ch ();
  cnms_out_if out_ch ();

  class_aware_nms_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Beats waiting to be driven and kept boxes waiting to be seen.
  cand_t     pending_boxes[$];
  kept_box_t expected_kept[$];

  // Shadow of the block: stored candidates, counters and registers.
  cand_t       stored[cnms_pkg::NCand];
  int unsigned stored_count = 0;
  logic        overflow_flag = 1'b0;
  logic [15:0] thr_shadow = cnms_pkg::ThrReset;
  logic [5:0]  keep_shadow = cnms_pkg::KeepReset;

  int  mismatches = 0;
  int  idle_cycles = 0;
  int  random_items = 0;
  bit  in_took = 1'b0;
  cand_t cur;

  function automatic logic [15:0] gap_of(input logic [15:0] lo, input logic [15:0] hi);
    gap_of = (hi > lo) ? hi - lo : 16'd0;
  endfunction

  // True when box b overlaps box a above the IoU threshold.
  function automatic bit too_close(input cand_t a, input cand_t b, input logic [15:0] thr);
    logic [15:0] il, it, ir, ib;
    logic [63:0] inter, area_a, area_b, uni;
    il = (a.lx > b.lx) ? a.lx : b.lx;
    it = (a.ty > b.ty) ? a.ty : b.ty;
    ir = (a.rx < b.rx) ? a.rx : b.rx;
    ib = (a.by < b.by) ? a.by : b.by;
    inter  = 64'(gap_of(il, ir)) * 64'(gap_of(it, ib));
    area_a = 64'(gap_of(a.lx, a.rx)) * 64'(gap_of(a.ty, a.by));
    area_b = 64'(gap_of(b.lx, b.rx)) * 64'(gap_of(b.ty, b.by));
    uni = area_a + area_b - inter;
    if (uni == 0) return 1'b0;
    return (inter << 16) > 64'(thr) * uni;
  endfunction

  // Store one accepted candidate; on the final beat, sort and suppress.
  task automatic take_candidate(input cand_t c);
    int unsigned order[$];
    bit          dead[$];
    int unsigned limit, j, pos;
    int          kept;
    kept_box_t   r;
    if (stored_count < cnms_pkg::NCand) begin
      stored[stored_count] = c;
      stored_count++;
    end else begin
      overflow_flag = 1'b1;
    end
    if (!c.fin) return;
    limit = (keep_shadow == 0) ? 1 :
            ((keep_shadow > cnms_pkg::MaxOut) ? cnms_pkg::MaxOut : keep_shadow);
    // Stable sort by score, highest first.
    for (int unsigned i = 0; i < stored_count; i++) begin
      pos = order.size();
      while (pos > 0 && stored[order[pos-1]].conf < stored[i].conf) pos--;
      order.insert(pos, i);
      dead.insert(dead.size(), 1'b0);
    end
    kept = 0;
    for (int unsigned i = 0; i < stored_count && kept < limit; i++) begin
      if (dead[i]) continue;
      r.found = 1'b1;
      r.lx = stored[order[i]].lx;
      r.ty = stored[order[i]].ty;
      r.rx = stored[order[i]].rx;
      r.by = stored[order[i]].by;
      r.cls = stored[order[i]].cls;
      r.conf = stored[order[i]].conf;
      r.idx = order[i][7:0];
      r.dropped = overflow_flag;
      r.last = 1'b0;
      expected_kept.insert(expected_kept.size(), r);
      kept++;
      for (j = i + 1; j < stored_count; j++) begin
        if (dead[j] || stored[order[i]].cls != stored[order[j]].cls) continue;
        if (too_close(stored[order[i]], stored[order[j]], thr_shadow)) dead[j] = 1'b1;
      end
    end
    if (kept == 0) begin
      r = '0;
      r.dropped = overflow_flag;
      r.last = 1'b1;
      expected_kept.insert(expected_kept.size(), r);
    end else begin
      expected_kept[expected_kept.size()-1].last = 1'b1;
    end
    stored_count = 0;
    overflow_flag = 1'b0;
  endtask

  // Input side: accept beats and feed the shadow.
  always @(posedge clk) begin
    in_took = in_ch.valid && in_ch.ready;
    if (in_took) take_candidate(cur);
  end

  // Output side: compare each kept box with the oldest expectation.
  always @(posedge clk) begin
    kept_box_t got;
    if (out_ch.valid && out_ch.ready) begin
      got = {out_ch.found, out_ch.out_left_x, out_ch.out_top_y, out_ch.out_right_x,
             out_ch.out_bottom_y, out_ch.out_class, out_ch.out_confidence,
             out_ch.arrival_index, out_ch.dropped_some, out_ch.run_end};
      if (expected_kept.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected kept box %h", got);
      end else begin
        if (got !== expected_kept[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("kept box mismatch: expected %h got %h", expected_kept[0], got);
        end
        void'(expected_kept.pop_front());
      end
    end
  end

  // Watchdog on cycles without any beat.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sender: bursts of beats with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n && !(in_ch.valid && !in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_boxes.size() > 0) begin
        cur = pending_boxes.pop_front();
        in_ch.left_x <= cur.lx;
        in_ch.top_y <= cur.ty;
        in_ch.right_x <= cur.rx;
        in_ch.bottom_y <= cur.by;
        in_ch.object_class <= cur.cls;
        in_ch.confidence <= cur.conf;
        in_ch.final_item <= cur.fin;
        in_ch.valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls on a rotating pattern, swapped now and then.
  logic [15:0] stall_pat = 16'hFFFF;
  int pat_age = 0;
  always @(negedge clk) begin
    if (pat_age == 63) begin
      stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
      pat_age <= 0;
    end else begin
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
      pat_age <= pat_age + 1;
    end
    out_ch.ready <= stall_pat[15];
  end

  task automatic push_box(input logic [15:0] lx, ty, rx, by, input logic [2:0] cls,
                          input logic [15:0] conf, input logic fin);
    cand_t c;
    c = '{lx, ty, rx, by, cls, conf, fin};
    pending_boxes.insert(pending_boxes.size(), c);
  endtask

  // Wait until every beat is taken and every kept box has come out.
  task automatic drain();
    do @(negedge clk);
    while (pending_boxes.size() != 0 || in_ch.valid || expected_kept.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  // One register write; the write enable is then held low before the task returns.
  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == cnms_pkg::CfgThr) thr_shadow = value;
    else keep_shadow = value[5:0];
    @(negedge clk);
  endtask

  // One run of boxes: mostly overlapping clusters, some pure noise.
  task automatic random_run(input int n);
    int cx, cy, w, h, base_cls, tie_conf;
    bit noise;
    noise = ($urandom_range(0, 4) == 0);
    cx = $urandom_range(0, 60000);
    cy = $urandom_range(0, 60000);
    w = $urandom_range(1, 4000);
    h = $urandom_range(1, 4000);
    base_cls = $urandom_range(0, 6);
    tie_conf = $urandom_range(0, 65535);
    for (int k = 0; k < n; k++) begin
      if (noise)
        push_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 3'($urandom), 16'($urandom), k == n - 1);
      else begin
        int jx, jy;
        jx = cx + $urandom_range(0, w / 3 + 1);
        jy = cy + $urandom_range(0, h / 3 + 1);
        push_box(16'(jx), 16'(jy), 16'(jx + w), 16'(jy + h),
                 3'(base_cls + $urandom_range(0, 1)),
                 ($urandom_range(0, 3) == 0) ? 16'(tie_conf) : 16'($urandom),
                 k == n - 1);
      end
    end
    random_items += n;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.left_x = '0;
    in_ch.top_y = '0;
    in_ch.right_x = '0;
    in_ch.bottom_y = '0;
    in_ch.object_class = '0;
    in_ch.confidence = '0;
    in_ch.final_item = 1'b0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Defaults: identical boxes of one class, the same box in another class,
    // an inverted box with no area, extreme corners and tied scores.
    push_box(16'd100, 16'd100, 16'd500, 16'd500, 3'd0, 16'hFFFF, 1'b0);
    push_box(16'd100, 16'd100, 16'd500, 16'd500, 3'd0, 16'h8000, 1'b0);
    push_box(16'd100, 16'd100, 16'd500, 16'd500, 3'd7, 16'h8000, 1'b0);
    push_box(16'd900, 16'd900, 16'd200, 16'd200, 3'd0, 16'h9000, 1'b0);
    push_box(16'd900, 16'd900, 16'd200, 16'd200, 3'd0, 16'h9000, 1'b0);
    push_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 3'd3, 16'h0000, 1'b0);
    push_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 3'd3, 16'h0000, 1'b0);
    push_box(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 3'd5, 16'h1234, 1'b1);
    push_box(16'd0, 16'd0, 16'd10, 16'd10, 3'd2, 16'd5, 1'b1);
    drain();

    // Lowest threshold with a keep limit of zero acting as one.
    write_reg(cnms_pkg::CfgThr, 16'd0);
    write_reg(cnms_pkg::CfgKeep, 6'd0);
    push_box(16'd0, 16'd0, 16'd100, 16'd100, 3'd1, 16'd50, 1'b0);
    push_box(16'd99, 16'd99, 16'd200, 16'd200, 3'd1, 16'd60, 1'b0);
    push_box(16'd300, 16'd300, 16'd400, 16'd400, 3'd1, 16'd70, 1'b1);
    drain();

    // Highest threshold with a keep limit above the output cap.
    write_reg(cnms_pkg::CfgThr, 16'hFFFF);
    write_reg(cnms_pkg::CfgKeep, 6'd63);
    push_box(16'd10, 16'd10, 16'd20, 16'd20, 3'd4, 16'd9, 1'b0);
    push_box(16'd10, 16'd10, 16'd20, 16'd20, 3'd4, 16'd9, 1'b0);
    push_box(16'd10, 16'd10, 16'd21, 16'd20, 3'd4, 16'd8, 1'b0);
    push_box(16'd10, 16'd10, 16'd20, 16'd20, 3'd6, 16'd7, 1'b1);
    drain();

    // Overflow: the store fills and the dropped last beat still ends the run.
    write_reg(cnms_pkg::CfgThr, 16'd32768);
    write_reg(cnms_pkg::CfgKeep, 6'd3);
    for (int k = 0; k < cnms_pkg::NCand + 2; k++)
      push_box(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
               16'($urandom_range(1000, 3000)), 16'($urandom_range(1000, 3000)),
               3'($urandom_range(0, 1)), 16'($urandom), k == cnms_pkg::NCand + 1);
    drain();

    write_reg(cnms_pkg::CfgKeep, 6'd32);
    write_reg(cnms_pkg::CfgThr, 16'd1);
    random_run(12);
    drain();

    // Random phases, each with its own register setting.
    while (random_items < 40) begin
      case ($urandom_range(0, 3))
        0: write_reg(cnms_pkg::CfgThr, 16'd0);
        1: write_reg(cnms_pkg::CfgThr, 16'hFFFF);
        default: write_reg(cnms_pkg::CfgThr, 16'($urandom));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(cnms_pkg::CfgKeep, 6'd1);
        1: write_reg(cnms_pkg::CfgKeep, 6'd32);
        default: write_reg(cnms_pkg::CfgKeep, 6'($urandom_range(0, 63)));
      endcase
      repeat ($urandom_range(2, 4)) random_run($urandom_range(1, 12));
      drain();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/cnms_pkg.sv
rtl/core/cnms_if.sv
rtl/core/cnms_store.sv
rtl/core/cnms_iou.sv
rtl/core/class_aware_nms_top.sv
rtl/core/cnms_chk.sv
bench/tb_top.sv
